// ----- rtl/core/linear_probe_hash_table_defines.svh -----
// assertion macros for the linear probing hash table
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// antecedent and consequent in the same cycle
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent starts in the following cycle
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/lpht_pkg.sv -----
// shared types, constants and helpers of the linear probing hash table
package lpht_pkg;

	localparam int TABLE_SIZE_DEF   = 8;
	localparam int VALUE_BITS_DEF   = 16;
	localparam int KEY_BUFFER_BYTES = 20;
	localparam int KEY_BYTES_MAX    = KEY_BUFFER_BYTES - 1;

	localparam int KEY_WORD_W = 64;
	localparam int KEY_HIGH_W = 24;
	localparam int KEY_W      = 2 * KEY_WORD_W + KEY_HIGH_W;
	localparam int KEY_BYTES  = KEY_W / 8;
	localparam int KEY_IDX_W  = $clog2(KEY_BYTES);
	localparam int LEN_W      = 5;
	localparam int VAL_W      = 16;
	localparam int SLOT_W     = 3;
	localparam int STATUS_W   = 3;
	localparam int SUM_W      = 10;
	localparam int SUM_MAX    = 3 * 255;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef struct packed {
		logic                  cmd;
		logic [KEY_WORD_W-1:0] key_low;
		logic [KEY_WORD_W-1:0] key_mid;
		logic [KEY_HIGH_W-1:0] key_high;
		logic [LEN_W-1:0]      key_length;
		logic [VAL_W-1:0]      value_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   slot;
		logic [VAL_W-1:0]    value_out;
	} rsp_t;

	typedef struct packed {
		logic    load;
		logic    sum_en;
		logic    home_en;
		logic    rd_en;
		logic    wr_en;
		logic    advance;
		logic    res_en;
		status_t res_status;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic key_hit;
		logic round_done;
		logic lookup;
		logic out_free;
	} dp_stat_t;

	// number of shifted compare and subtract steps that bring the byte sum below ts
	function automatic int mod_steps(input int ts);
		int n;
		n = 0;
		for (int k = 0; k < SUM_W; k++) begin
			if ((ts << k) <= SUM_MAX) begin
				n = k + 1;
			end
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/lpht_ram.sv -----
// generic ram, one write port and one read port with registered read data
module lpht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/core/lpht_ctrl.sv -----
// controller state machine of the linear probing hash table
module lpht_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  lpht_pkg::dp_stat_t stat,
	output lpht_pkg::dp_cmd_t  cmd
);

	import lpht_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SUM   = 6'b000010,
		S_HOME  = 6'b000100,
		S_PROBE = 6'b001000,
		S_CHECK = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum_en = 1'b1;
				state_d    = S_HOME;
			end
			S_HOME: begin
				cmd.home_en = 1'b1;
				state_d     = S_PROBE;
			end
			S_PROBE: begin
				if (stat.slot_free) begin
					cmd.res_en = 1'b1;
					cmd.wr_en  = !stat.lookup;
					if (stat.lookup) begin
						cmd.res_status = ST_NOT_FOUND;
					end else begin
						cmd.res_status = ST_INSERTED;
					end
					state_d = S_RESP;
				end else begin
					cmd.rd_en = 1'b1;
					state_d   = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.key_hit) begin
					cmd.res_en = 1'b1;
					cmd.wr_en  = !stat.lookup;
					if (stat.lookup) begin
						cmd.res_status = ST_FOUND;
					end else begin
						cmd.res_status = ST_UPDATED;
					end
					state_d = S_RESP;
				end else if (stat.round_done) begin
					cmd.res_en = 1'b1;
					if (stat.lookup) begin
						cmd.res_status = ST_NOT_FOUND;
					end else begin
						cmd.res_status = ST_FULL;
					end
					state_d = S_RESP;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_PROBE;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/core/lpht_datapath.sv -----
// datapath of the linear probing hash table: key capture, hashing, probe, table and result
module lpht_datapath #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
	parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lpht_pkg::req_t     req,
	input  lpht_pkg::dp_cmd_t  cmd,
	output lpht_pkg::dp_stat_t stat,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lpht_pkg::rsp_t     rsp
);

	import lpht_pkg::*;

	localparam int IDX_W     = $clog2(TABLE_SIZE);
	localparam int ENTRY_W   = KEY_W + LEN_W + VALUE_BITS;
	localparam int MOD_STEPS = mod_steps(TABLE_SIZE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	logic                  cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [LEN_W-1:0]      len_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [SUM_W-1:0]      sum_q;
	logic [IDX_W-1:0]      probe_q;
	logic [IDX_W-1:0]      count_q;
	logic [TABLE_SIZE-1:0] valid_q;
	status_t               res_status_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	logic [LEN_W-1:0]            len_c;
	logic [KEY_W-1:0]            key_raw;
	logic [KEY_W-1:0]            key_c;
	logic [VALUE_BITS+VAL_W-1:0] val_ext;
	logic [KEY_IDX_W-1:0]        mid_idx;
	logic [KEY_IDX_W-1:0]        last_idx;
	logic [SUM_W-1:0]            sum_d;
	logic [SUM_W-1:0]            rem;
	logic [IDX_W-1:0]            home;
	logic [ENTRY_W-1:0]          ram_rdata;
	logic [IDX_W+SLOT_W-1:0]     slot_ext;
	logic [VALUE_BITS+VAL_W-1:0] stored_ext;
	logic [VALUE_BITS+VAL_W-1:0] new_ext;
	rsp_t                        rsp_d;

	// clamp the length and clear bytes beyond it
	always_comb begin
		if (req.key_length == '0) begin
			len_c = LEN_W'(1);
		end else if (req.key_length > LEN_W'(KEY_BYTES_MAX)) begin
			len_c = LEN_W'(KEY_BYTES_MAX);
		end else begin
			len_c = req.key_length;
		end
		key_raw = {req.key_high, req.key_mid, req.key_low};
		for (int i = 0; i < KEY_BYTES; i++) begin
			key_c[8*i +: 8] = (i < int'(len_c)) ? key_raw[8*i +: 8] : 8'h00;
		end
	end

	assign val_ext = {{VALUE_BITS{1'b0}}, req.value_in};

	// first, middle and last byte
	assign mid_idx  = KEY_IDX_W'(len_q >> 1);
	assign last_idx = KEY_IDX_W'(len_q - LEN_W'(1));
	assign sum_d    = SUM_W'(key_q[7:0]) + SUM_W'(key_q[8*mid_idx +: 8])
		+ SUM_W'(key_q[8*last_idx +: 8]);

	// home slot by shifted compare and subtract
	always_comb begin
		rem = sum_q;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (rem >= SUM_W'(TABLE_SIZE << k)) begin
				rem = rem - SUM_W'(TABLE_SIZE << k);
			end
		end
		home = rem[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= req.cmd;
			key_q <= key_c;
			len_q <= len_c;
			val_q <= val_ext[VALUE_BITS-1:0];
		end
		if (cmd.sum_en) begin
			sum_q <= sum_d;
		end
		if (cmd.home_en) begin
			probe_q <= home;
			count_q <= '0;
		end else if (cmd.advance) begin
			probe_q <= (probe_q == LAST_IDX) ? '0 : probe_q + IDX_W'(1);
			count_q <= count_q + IDX_W'(1);
		end
		if (cmd.res_en) begin
			res_status_q <= cmd.res_status;
		end
		if (cmd.out_load) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				valid_q[probe_q] <= 1'b1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	lpht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk     (clk),
		.wr_en   (cmd.wr_en),
		.wr_addr (probe_q),
		.wr_data ({key_q, len_q, val_q}),
		.rd_en   (cmd.rd_en),
		.rd_addr (probe_q),
		.rd_data (ram_rdata)
	);

	assign stat.slot_free  = !valid_q[probe_q];
	assign stat.key_hit    = (ram_rdata[ENTRY_W-1 -: KEY_W+LEN_W] == {key_q, len_q});
	assign stat.round_done = (count_q == LAST_IDX);
	assign stat.lookup     = (cmd_q == CMD_LOOKUP);
	assign stat.out_free   = !rsp_valid_q || !rsp_stall;

	assign slot_ext   = {{SLOT_W{1'b0}}, probe_q};
	assign stored_ext = {{VAL_W{1'b0}}, ram_rdata[VALUE_BITS-1:0]};
	assign new_ext    = {{VAL_W{1'b0}}, val_q};

	always_comb begin
		rsp_d.status = res_status_q;
		case (res_status_q) inside
			ST_FOUND: begin
				rsp_d.slot      = slot_ext[SLOT_W-1:0];
				rsp_d.value_out = stored_ext[VAL_W-1:0];
			end
			ST_INSERTED, ST_UPDATED: begin
				rsp_d.slot      = slot_ext[SLOT_W-1:0];
				rsp_d.value_out = new_ext[VAL_W-1:0];
			end
			default: begin
				rsp_d.slot      = '0;
				rsp_d.value_out = '0;
			end
		endcase
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// ----- rtl/core/linear_probe_hash_table.sv -----
// linear probing hash table: top level joining controller and datapath
// one transaction at a time: after acceptance the block forms the byte sum, then the home
// slot, then probes slot after slot until a free slot, a key match or a full round, and then
// loads the result; the table ram is read for each occupied slot passed over, and a stalled
// result holds the next one
// asynchronous reset clears the slot valid bits, the state machine and the output valid
module linear_probe_hash_table #(
	parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF,
	parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lpht_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lpht_pkg::rsp_t rsp
);

	import lpht_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	lpht_datapath #(
		.TABLE_SIZE (TABLE_SIZE),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (dp_cmd),
		.stat      (dp_stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ----- rtl/core/lpht_checker.sv -----
// port level checks of the linear probing hash table and their bind
`include "linear_probe_hash_table_defines.svh"

module lpht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input lpht_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input lpht_pkg::rsp_t rsp
);

	import lpht_pkg::*;

	// hashing and the first probe keep the block busy
	`LPHT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall ##1 req_stall ##1 req_stall, "new transaction taken during hashing")

	// a fresh result only comes out of a busy block
	`LPHT_ASSERT_NOW(a_rsp_after_busy, clk, arst_n, $rose(rsp_valid), $past(req_stall), "result without a transaction in flight")

	// misses and a full table report slot and value as zero
	`LPHT_ASSERT_NOW(a_miss_zero, clk, arst_n, rsp_valid && (rsp.status == ST_NOT_FOUND || rsp.status == ST_FULL), rsp.slot == '0 && rsp.value_out == '0, "miss with nonzero slot or value")

	// a stalled result stays put
	`LPHT_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")

endmodule

bind linear_probe_hash_table lpht_checker u_checker (.*);

// ----- test/hash_table_checker.sv -----
// checker for the linear probing hash table: predicts every result and compares it
module hash_table_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  lpht_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  lpht_pkg::rsp_t rsp,
	output int             pending,
	output int             mismatches
);
	timeunit 1ns;
	timeprecision 1ps;
	import lpht_pkg::*;

	localparam int SLOTS = TABLE_SIZE_DEF;

	logic             slot_used  [SLOTS];
	logic [KEY_W-1:0] slot_key   [SLOTS];
	int               slot_len   [SLOTS];
	logic [VAL_W-1:0] slot_value [SLOTS];
	rsp_t             table_answers[$];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i]  = 1'b0;
			slot_key[i]   = '0;
			slot_len[i]   = 0;
			slot_value[i] = '0;
		end
	end

	function automatic rsp_t apply_to_table(req_t r);
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] keep;
		int               len;
		int               sum;
		int               home;
		int               s;
		logic             hit;
		rsp_t             o;
		len = r.key_length;
		if (len < 1) len = 1;
		if (len > KEY_BYTES_MAX) len = KEY_BYTES_MAX;
		keep = '0;
		for (int b = 0; b < len; b++) keep[b*8 +: 8] = 8'hFF;
		key = {r.key_high, r.key_mid, r.key_low} & keep;
		sum = int'(key[7:0]) + int'(key[(len/2)*8 +: 8]) + int'(key[(len-1)*8 +: 8]);
		home = sum % SLOTS;
		// search stops at a free slot, a match or after one full round
		hit = 1'b0;
		s = home;
		for (int n = 0; n < SLOTS; n++) begin
			if (!slot_used[s]) break;
			if (slot_len[s] == len && slot_key[s] == key) begin
				hit = 1'b1;
				break;
			end
			s = (s + 1) % SLOTS;
		end
		o = '0;
		o.status = ST_NOT_FOUND;
		if (r.cmd == CMD_LOOKUP) begin
			if (hit) begin
				o.status    = ST_FOUND;
				o.slot      = SLOT_W'(s);
				o.value_out = slot_value[s];
			end
		end else if (hit) begin
			slot_value[s] = r.value_in;
			o.status      = ST_UPDATED;
			o.slot        = SLOT_W'(s);
			o.value_out   = r.value_in;
		end else begin
			o.status = ST_FULL;
			s = home;
			for (int n = 0; n < SLOTS; n++) begin
				if (!slot_used[s]) begin
					slot_used[s]  = 1'b1;
					slot_key[s]   = key;
					slot_len[s]   = len;
					slot_value[s] = r.value_in;
					o.status      = ST_INSERTED;
					o.slot        = SLOT_W'(s);
					o.value_out   = r.value_in;
					break;
				end
				s = (s + 1) % SLOTS;
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		mismatches++;
		if (mismatches <= 40)
			$display("%0t ns: %s mismatch, got %h, expected %h", $realtime, what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			pending <= 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (table_answers.size() == 0) begin
					report_mismatch("unexpected transaction, status", 32'(rsp.status), '0);
				end else begin
					want = table_answers.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.slot !== want.slot)
						report_mismatch("slot", 32'(rsp.slot), 32'(want.slot));
					if (rsp.value_out !== want.value_out)
						report_mismatch("value", 32'(rsp.value_out), 32'(want.value_out));
				end
			end
			if (req_valid && !req_stall)
				table_answers.push_back(apply_to_table(req));
			pending <= table_answers.size();
		end
	end

endmodule

// ----- test/testbench.sv -----
// top of the hash table testbench: clock, reset, stimulus, output stalls and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lpht_pkg::*;

	localparam int RANDOM_ITEMS = 1830;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 4 + 2 * TABLE_SIZE_DEF;
	localparam int LONG_HOLD    = 300;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	logic rsp_valid;
	logic rsp_stall;
	req_t req;
	rsp_t rsp;

	int pending;
	int mismatches;
	int cycles;
	int sent;
	int lookups;
	int inserts;
	bit no_gaps;

	logic [KEY_W-1:0] known_keys[$];
	int               known_lens[$];

	linear_probe_hash_table dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	hash_table_checker watch (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp,
		.pending,
		.mismatches
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [KEY_W-1:0] random_bytes();
		logic [159:0] w;
		w = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
		return w[KEY_W-1:0];
	endfunction

	function automatic logic [VAL_W-1:0] any_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return VAL_W'($urandom());
		endcase
	endfunction

	// key bytes kept up to the effective length, zero or junk beyond it
	function automatic logic [KEY_W-1:0] pad_key(logic [KEY_W-1:0] k, int len_field);
		logic [KEY_W-1:0] junk;
		int               l;
		l = len_field;
		if (l < 1) l = 1;
		if (l > KEY_BYTES_MAX) l = KEY_BYTES_MAX;
		junk = $urandom_range(0, 1) ? random_bytes() : '0;
		for (int b = 0; b < l; b++) junk[b*8 +: 8] = k[b*8 +: 8];
		return junk;
	endfunction

	function automatic logic pick_cmd();
		return $urandom_range(0, 1) ? CMD_LOOKUP : CMD_INSERT;
	endfunction

	task automatic remember(logic [KEY_W-1:0] k, int l);
		known_keys.push_back(k);
		known_lens.push_back(l);
	endtask

	task automatic offer(logic cmd, logic [KEY_W-1:0] key, int len_field,
			logic [VAL_W-1:0] value);
		req_t r;
		int   gap;
		r.cmd        = cmd;
		r.key_low    = key[63:0];
		r.key_mid    = key[127:64];
		r.key_high   = key[151:128];
		r.key_length = len_field[LEN_W-1:0];
		r.value_in   = value;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		sent++;
		if (cmd == CMD_LOOKUP) lookups++;
		else inserts++;
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// output side: random stall per transaction, one long hold-off
	initial begin
		int n;
		int taken;
		taken = 0;
		rsp_stall <= 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 700) n = LONG_HOLD;
			else if (no_gaps) n = 0;
			else n = $urandom_range(0, 15);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			taken++;
		end
	end

	initial begin
		logic [KEY_W-1:0] k;
		int               idx;
		int               l;
		int               len_field;
		int               pick;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then a one-byte key with zero or junk bytes past its length
		offer(CMD_LOOKUP, random_bytes(), 7, any_value());
		k = '0;
		k[7:0] = 8'hFF;
		remember(k, 1);
		offer(CMD_INSERT, pad_key(k, 1), 1, 16'hFFFF);
		offer(CMD_LOOKUP, pad_key(k, 1), 1, any_value());
		offer(CMD_INSERT, pad_key(k, 0), 0, 16'h0000);
		// longest key, also reached through over-long lengths
		k = '1;
		remember(k, KEY_BYTES_MAX);
		offer(CMD_INSERT, k, KEY_BYTES_MAX, 16'h1234);
		offer(CMD_LOOKUP, k, 31, any_value());
		offer(CMD_LOOKUP, k, KEY_BUFFER_BYTES, any_value());
		// all-zero keys of different lengths share a home slot
		remember('0, 5);
		remember('0, 3);
		offer(CMD_INSERT, pad_key('0, 5), 5, 16'h5555);
		offer(CMD_INSERT, pad_key('0, 3), 3, 16'hAAAA);
		offer(CMD_LOOKUP, pad_key('0, 4), 4, any_value());
		offer(CMD_LOOKUP, pad_key('0, 3), 3, any_value());
		// fill the rest, the last insert meets a full table
		repeat (TABLE_SIZE_DEF - 3) begin
			l = $urandom_range(1, KEY_BYTES_MAX);
			k = random_bytes();
			remember(k, l);
			offer(CMD_INSERT, pad_key(k, l), l, any_value());
		end
		offer(CMD_LOOKUP, random_bytes(), $urandom_range(1, KEY_BYTES_MAX), any_value());
		offer(CMD_INSERT, pad_key('0, 3), 3, 16'hFFFF);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			no_gaps = (i >= 400 && i < 550) || (i >= 1300 && i < 1400);
			if (i == 1000) drain();
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				idx = $urandom_range(0, known_keys.size() - 1);
				l = known_lens[idx];
				len_field = l;
				if (l == 1 && $urandom_range(0, 2) == 0) len_field = 0;
				if (l == KEY_BYTES_MAX && $urandom_range(0, 1) == 1)
					len_field = $urandom_range(KEY_BUFFER_BYTES, 31);
				offer(pick_cmd(), pad_key(known_keys[idx], len_field), len_field, any_value());
			end else if (pick < 85) begin
				l = $urandom_range(1, KEY_BYTES_MAX);
				offer(pick_cmd(), pad_key(random_bytes(), l), l, any_value());
			end else begin
				offer(pick_cmd(), random_bytes(), $urandom_range(0, 31), any_value());
			end
		end
		no_gaps = 1'b0;
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);

		$display("covered %0d transactions: %0d look-ups, %0d inserts or updates, %0d cycles",
			sent, lookups, inserts, cycles);
		$display("keys of declared length 0 to 31, collisions, full table, long output hold-off");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- linear_probe_hash_table.f -----
+incdir+rtl/core
rtl/core/lpht_pkg.sv
rtl/core/lpht_ram.sv
rtl/core/lpht_ctrl.sv
rtl/core/lpht_datapath.sv
rtl/core/linear_probe_hash_table.sv
rtl/core/lpht_checker.sv
test/hash_table_checker.sv
test/testbench.sv
